[rtl/gpcei_pkg.sv]
// Shared types and constants for the gated power curve energy integrator.
package gpcei_pkg;

  localparam int CurvePoints = 16;
  localparam int IdxW = $clog2(CurvePoints);
  localparam int Channels = 3;
  localparam logic [59:0] AccMax = {60{1'b1}};
  localparam logic [47:0] EnergyMax = {48{1'b1}};
  localparam logic [11:0] Div3600 = 12'd3600;
  // ceil(2^40 / 3600): exact quotient for any 28-bit dividend
  localparam logic [28:0] Recip3600 = 29'd305419897;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STATUS = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  localparam logic [2:0] REG_POINTS = 3'd0;
  localparam logic [2:0] REG_CHANS  = 3'd1;
  localparam logic [2:0] REG_C0_LO  = 3'd2;
  localparam logic [2:0] REG_C0_HI  = 3'd3;
  localparam logic [2:0] REG_C1_LO  = 3'd4;
  localparam logic [2:0] REG_C1_HI  = 3'd5;
  localparam logic [2:0] REG_C2_LO  = 3'd6;
  localparam logic [2:0] REG_C2_HI  = 3'd7;

  // controller -> datapath
  typedef struct packed {
    logic capture;      // latch input item
    logic search_init;  // start segment search from top
    logic search_step;  // test one breakpoint
    logic mul_go;       // delta*off product, start divider
    logic div_step;     // one divider step
    logic pwr_done;     // form power
    logic acc_mul;      // power * dt
    logic acc_add;      // update run state
    logic fin_init;     // start energy / 3600
    logic fin_load;     // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search_hit;   // segment found or exhausted
    logic need_div;     // interpolation needs division
    logic div_last;     // final divider step
  } sts_t;

endpackage

[rtl/gpcei_ctrl.sv]
// Controller state machine for the energy integrator.
module gpcei_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_operation,
  output logic              in_stall,
  input  logic              out_full,
  output gpcei_pkg::cmd_t   cmd,
  input  gpcei_pkg::sts_t   sts
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_MUL    = 9'b000000100,
    S_DIV    = 9'b000001000,
    S_PWR    = 9'b000010000,
    S_AMUL   = 9'b000100000,
    S_ACC    = 9'b001000000,
    S_FDIV   = 9'b010000000,
    S_FOUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic take;

  assign in_stall = (state_r != S_IDLE);
  assign take = in_valid && (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.capture = 1'b1;
          if (in_operation == gpcei_pkg::OP_SAMPLE) begin
            cmd.search_init = 1'b1;
            state_nxt = S_SEARCH;
          end else if (in_operation == gpcei_pkg::OP_FINISH) begin
            cmd.fin_init = 1'b1;
            state_nxt = S_FDIV;
          end
        end
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (sts.search_hit) state_nxt = S_MUL;
      end
      S_MUL: begin
        if (sts.need_div) begin
          cmd.mul_go = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_PWR;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_PWR;
      end
      S_PWR: begin
        cmd.pwr_done = 1'b1;
        state_nxt = S_AMUL;
      end
      S_AMUL: begin
        cmd.acc_mul = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FOUT;
      end
      S_FOUT: begin
        if (!out_full) begin
          cmd.fin_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

[rtl/gpcei_dp.sv]
// Datapath: curve memory, segment search, divider, accumulator, config.
module gpcei_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gpcei_pkg::cmd_t        cmd,
  output gpcei_pkg::sts_t        sts,
  input  logic [1:0]             in_operation,
  input  logic [3:0]             in_slot_index,
  input  logic [15:0]            in_speed,
  input  logic [19:0]            in_curve_power,
  input  logic signed [15:0]     in_status_value,
  input  logic [31:0]            in_sample_time,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_idx,
  input  logic [31:0]            cfg_wdata,
  output logic [31:0]            cfg_rdata,
  output logic                   out_full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [47:0]            out_energy,
  output logic [31:0]            out_sample_count,
  output logic [31:0]            out_first_time,
  output logic [31:0]            out_last_time
);

  localparam int IW = gpcei_pkg::IdxW;

  logic [15:0] spd_mem [gpcei_pkg::CurvePoints];
  logic [19:0] pwr_mem [gpcei_pkg::CurvePoints];

  logic [4:0] npts_r;
  logic [1:0] nch_r;
  logic signed [15:0] lo_r [gpcei_pkg::Channels];
  logic signed [15:0] hi_r [gpcei_pkg::Channels];
  logic signed [15:0] lat_r [gpcei_pkg::Channels];
  logic [gpcei_pkg::Channels-1:0] seen_r;

  logic [31:0] prev_r, first_r, cnt_r;
  logic [59:0] acc_r;

  logic [15:0] sspd_r;
  logic [31:0] stime_r;

  // search
  logic [IW:0] idx_r;          // current candidate + 1 (0 = none)
  logic found_r, last_seg_r;
  logic [15:0] s0_r, s1_r;
  logic [19:0] p0_r, p1_r;
  logic [IW-1:0] ci;
  logic [4:0] nlim;

  // divider (interpolation)
  logic [59:0] num_r;
  logic [59:0] rem_r;
  logic [16:0] den_r;
  logic [5:0] dcnt_r;
  logic neg_r, fin_r;
  logic [35:0] prod;
  logic [19:0] pwr_r;
  logic [51:0] amul_r;

  // energy / 3600: four 16-bit digits, each an estimate step then a remainder step
  logic [63:0] fnum_r, fquo_r;
  logic [11:0] frem_r;
  logic [15:0] fqd_r;
  logic [27:0] fv, fback, fdiff;
  logic [56:0] fprod;

  assign nlim = (npts_r > 5'(gpcei_pkg::CurvePoints)) ?
                5'(gpcei_pkg::CurvePoints) : npts_r;
  assign ci = IW'(idx_r - 1'b1);

  // segment search: one breakpoint per cycle, from the top
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      idx_r <= (IW+1)'(nlim);
      found_r <= 1'b0;
      last_seg_r <= 1'b1;
      s1_r <= '0;
      p1_r <= '0;
    end else if (cmd.search_step && !sts.search_hit) begin
      s0_r <= spd_mem[ci];
      p0_r <= pwr_mem[ci];
      if (sspd_r >= spd_mem[ci]) begin
        found_r <= 1'b1;
      end else begin
        s1_r <= spd_mem[ci];
        p1_r <= pwr_mem[ci];
        last_seg_r <= 1'b0;
        idx_r <= idx_r - 1'b1;
      end
    end
  end
  assign sts.search_hit = found_r || (idx_r == '0);
  assign sts.need_div = found_r && !last_seg_r && (s1_r > s0_r);

  logic [16:0] off;
  logic [20:0] dlt;
  assign off = {1'b0, sspd_r} - {1'b0, s0_r};
  assign dlt = (p1_r >= p0_r) ? {1'b0, p1_r - p0_r} : {1'b0, p0_r - p1_r};
  assign prod = 36'(dlt[19:0]) * 36'(off[15:0]);

  logic [60:0] rtry;
  logic [59:0] rsh;
  assign rsh = {rem_r[58:0], num_r[59]};
  assign rtry = {1'b0, rsh} - {44'b0, den_r};
  assign sts.div_last = fin_r ? (dcnt_r == 6'd7) : (dcnt_r == 6'd59);

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      num_r <= {24'b0, prod};
      rem_r <= '0;
      den_r <= {1'b0, s1_r} - {1'b0, s0_r};
      dcnt_r <= '0;
      neg_r <= (p1_r < p0_r);
      fin_r <= 1'b0;
    end else if (cmd.fin_init) begin
      dcnt_r <= '0;
      fin_r <= 1'b1;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (!fin_r) begin
        if (!rtry[60]) begin
          rem_r <= rtry[59:0];
          num_r <= {num_r[58:0], 1'b1};
        end else begin
          rem_r <= rsh;
          num_r <= {num_r[58:0], 1'b0};
        end
      end
    end
  end

  assign fv = {frem_r, fnum_r[63:48]};
  assign fprod = 57'(fv) * 57'(gpcei_pkg::Recip3600);
  assign fback = 28'(fqd_r) * 28'(gpcei_pkg::Div3600);
  assign fdiff = fv - fback;

  always_ff @(posedge clk) begin
    if (cmd.fin_init) begin
      fnum_r <= {4'b0, acc_r};
      fquo_r <= '0;
      frem_r <= '0;
    end else if (cmd.div_step && fin_r) begin
      if (!dcnt_r[0]) begin
        fqd_r <= fprod[55:40];
      end else begin
        frem_r <= fdiff[11:0];
        fquo_r <= {fquo_r[47:0], fqd_r};
        fnum_r <= {fnum_r[47:0], 16'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pwr_done) begin
      if (!found_r) pwr_r <= '0;
      else if (!sts.need_div) pwr_r <= p0_r;
      else if (neg_r) pwr_r <= p0_r - num_r[19:0];
      else pwr_r <= p0_r + num_r[19:0];
    end
    if (cmd.acc_mul) amul_r <= 52'(pwr_r) * 52'(stime_r - prev_r);
  end

  // gate
  logic gate;
  always_comb begin
    gate = 1'b0;
    for (int k = 0; k < gpcei_pkg::Channels; k++) begin
      if (2'(k) < nch_r && seen_r[k] && lat_r[k] >= lo_r[k] && lat_r[k] <= hi_r[k])
        gate = 1'b1;
    end
  end

  logic [60:0] asum;
  assign asum = {1'b0, acc_r} + {9'b0, amul_r};

  // input capture, memories, run state
  always_ff @(posedge clk) begin
    if (cmd.capture && in_operation == gpcei_pkg::OP_LOAD) begin
      spd_mem[in_slot_index[IW-1:0]] <= in_speed;
      pwr_mem[in_slot_index[IW-1:0]] <= in_curve_power;
    end
    if (cmd.capture) begin
      sspd_r <= in_speed;
      stime_r <= in_sample_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      prev_r <= '0;
      first_r <= '0;
      cnt_r <= '0;
      acc_r <= '0;
      npts_r <= '0;
      nch_r <= '0;
      for (int k = 0; k < gpcei_pkg::Channels; k++) begin
        lat_r[k] <= '0;
        lo_r[k] <= '0;
        hi_r[k] <= '0;
      end
    end else begin
      if (cmd.capture && in_operation == gpcei_pkg::OP_STATUS &&
          in_slot_index < 4'(gpcei_pkg::Channels)) begin
        lat_r[in_slot_index[1:0]] <= in_status_value;
        seen_r[in_slot_index[1:0]] <= 1'b1;
      end
      if (cmd.acc_add) begin
        if (cnt_r == '0) first_r <= stime_r;
        else if (stime_r >= prev_r && gate)
          acc_r <= asum[60] ? gpcei_pkg::AccMax : asum[59:0];
        prev_r <= stime_r;
        if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.fin_load) begin
        prev_r <= '0;
        first_r <= '0;
        cnt_r <= '0;
        acc_r <= '0;
      end
      if (cfg_we) begin
        if (cfg_idx == gpcei_pkg::REG_POINTS) npts_r <= cfg_wdata[4:0];
        else if (cfg_idx == gpcei_pkg::REG_CHANS) nch_r <= cfg_wdata[1:0];
        else if (cfg_idx[0]) hi_r[2'((cfg_idx - 3'd2) >> 1)] <= cfg_wdata[15:0];
        else lo_r[2'((cfg_idx - 3'd2) >> 1)] <= cfg_wdata[15:0];
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      gpcei_pkg::REG_POINTS: cfg_rdata = {27'b0, npts_r};
      gpcei_pkg::REG_CHANS:  cfg_rdata = {30'b0, nch_r};
      default: cfg_rdata = cfg_idx[0] ? {{16{hi_r[2'((cfg_idx - 3'd2) >> 1)][15]}},
                                          hi_r[2'((cfg_idx - 3'd2) >> 1)]}
                                      : {{16{lo_r[2'((cfg_idx - 3'd2) >> 1)][15]}},
                                          lo_r[2'((cfg_idx - 3'd2) >> 1)]};
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.fin_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (cmd.fin_load) begin
      out_energy <= (fquo_r[63:48] != '0) ? gpcei_pkg::EnergyMax : fquo_r[47:0];
      out_sample_count <= cnt_r;
      out_first_time <= first_r;
      out_last_time <= prev_r;
    end
  end
  assign out_full = out_valid && out_stall;

  logic unused;
  assign unused = (^off[16]) ^ dlt[20] ^ (^fdiff[27:12]) ^ fprod[56] ^ (^fprod[39:0]);

endmodule

[rtl/gated_power_curve_energy_integrator_unit.sv]
// Top level of the gated power curve energy integrator.
// Sample path: search, optional 60-step divide, power, product, accumulate;
// finish runs the energy / 3600 divider, then loads the output register when not full.
// One item at a time: the input stalls until the item is done.
// Reset (rst_n, synchronous): clears config registers, channels and run; curve memory
// is not cleared.
module gated_power_curve_energy_integrator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_slot_index,
  input  logic [15:0]        in_speed,
  input  logic [19:0]        in_curve_power,
  input  logic signed [15:0] in_status_value,
  input  logic [31:0]        in_sample_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [47:0]        out_energy,
  output logic [31:0]        out_sample_count,
  output logic [31:0]        out_first_time,
  output logic [31:0]        out_last_time,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  gpcei_pkg::cmd_t cmd;
  gpcei_pkg::sts_t sts;
  logic out_full;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[4:2] <= 3'd7);

  gpcei_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_operation, .in_stall, .out_full, .cmd, .sts
  );

  gpcei_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_operation, .in_slot_index, .in_speed,
    .in_curve_power, .in_status_value, .in_sample_time,
    .cfg_we, .cfg_idx(paddr[4:2]), .cfg_wdata(pwdata), .cfg_rdata(prdata),
    .out_full, .out_valid, .out_stall, .out_energy, .out_sample_count,
    .out_first_time, .out_last_time
  );

  logic unused;
  assign unused = ^paddr[1:0];

endmodule

[rtl/gpcei_checker.sv]
// Port-level checker for the energy integrator, bound to the top level.
module gpcei_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_sample_count,
  input logic [31:0] out_first_time,
  input logic        pready
);

  a_pready: assert property (@(posedge clk) pready) else $error("pready low");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_count))
    else $error("stalled result changed");

  a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_count == '0 |-> out_first_time == '0)
    else $error("empty run has first time");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation == gpcei_pkg::OP_SAMPLE |=> in_stall)
    else $error("sample not processed");

endmodule

bind gated_power_curve_energy_integrator_unit gpcei_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .in_operation, .out_valid, .out_stall,
  .out_sample_count, .out_first_time, .pready
);

[bench/gated_power_curve_energy_integrator_unit_tb.sv]
// Testbench for the gated power curve energy integrator: scoreboard prediction and random traffic.
`timescale 1ns / 1ps
module gated_power_curve_energy_integrator_unit_tb;

  localparam logic [59:0] ACC_SAT = {60{1'b1}};
  localparam logic [47:0] ENERGY_SAT = {48{1'b1}};

  typedef struct packed {
    logic [47:0] energy;
    logic [31:0] count;
    logic [31:0] first_t;
    logic [31:0] last_t;
  } summary_t;

  class energy_scoreboard;
    logic [15:0] spd_tab[gpcei_pkg::CurvePoints];
    logic [19:0] pwr_tab[gpcei_pkg::CurvePoints];
    logic signed [15:0] chan_val[gpcei_pkg::Channels];
    bit chan_seen[gpcei_pkg::Channels];
    logic signed [15:0] lo[gpcei_pkg::Channels];
    logic signed [15:0] hi[gpcei_pkg::Channels];
    int unsigned npts, nchan;
    logic [31:0] prev_t, first_t, cnt;
    logic [59:0] acc;
    summary_t pending[$];
    int errors, results;

    function new();
      for (int k = 0; k < gpcei_pkg::CurvePoints; k++) begin
        spd_tab[k] = 0;
        pwr_tab[k] = 0;
      end
      for (int k = 0; k < gpcei_pkg::Channels; k++) begin
        chan_val[k] = 0;
        chan_seen[k] = 0;
        lo[k] = 0;
        hi[k] = 0;
      end
      npts = 0;
      nchan = 0;
      prev_t = 0;
      first_t = 0;
      cnt = 0;
      acc = 0;
      errors = 0;
      results = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] v);
      if (idx == gpcei_pkg::REG_POINTS) npts = v[4:0];
      else if (idx == gpcei_pkg::REG_CHANS) nchan = v[1:0];
      else if (idx[0] == 0) lo[(idx - 2) / 2] = v[15:0];
      else hi[(idx - 2) / 2] = v[15:0];
    endfunction

    function logic [31:0] curve_power(logic [15:0] s);
      int n;
      longint d, o, dl;
      n = npts > gpcei_pkg::CurvePoints ? gpcei_pkg::CurvePoints : npts;
      for (int i = n - 1; i >= 0; i--) begin
        if (s >= spd_tab[i]) begin
          if (i == n - 1) return pwr_tab[i];
          d = longint'(spd_tab[i + 1]) - longint'(spd_tab[i]);
          o = longint'(s) - longint'(spd_tab[i]);
          dl = longint'(pwr_tab[i + 1]) - longint'(pwr_tab[i]);
          if (d <= 0) return pwr_tab[i];
          return 32'(longint'(pwr_tab[i]) + (dl * o) / d);
        end
      end
      return 0;
    endfunction

    function bit gate_open();
      int n;
      n = nchan > gpcei_pkg::Channels ? gpcei_pkg::Channels : nchan;
      for (int k = 0; k < n; k++)
        if (chan_seen[k] && chan_val[k] >= lo[k] && chan_val[k] <= hi[k]) return 1;
      return 0;
    endfunction

    function void note_transfer(logic [1:0] op, logic [3:0] slot, logic [15:0] spd,
                                logic [19:0] pw, logic signed [15:0] st, logic [31:0] t);
      logic [31:0] p;
      logic [63:0] add;
      logic [59:0] q;
      summary_t r;
      case (gpcei_pkg::op_t'(op))
        gpcei_pkg::OP_LOAD: begin
          spd_tab[slot] = spd;
          pwr_tab[slot] = pw;
        end
        gpcei_pkg::OP_STATUS: begin
          if (slot < gpcei_pkg::Channels) begin
            chan_val[slot] = st;
            chan_seen[slot] = 1;
          end
        end
        gpcei_pkg::OP_SAMPLE: begin
          p = curve_power(spd);
          if (cnt == 0) first_t = t;
          else if (t >= prev_t && gate_open()) begin
            add = 64'(p) * 64'(t - prev_t);
            if (add > 64'(ACC_SAT - acc)) acc = ACC_SAT;
            else acc = acc + 60'(add);
          end
          prev_t = t;
          if (cnt != 32'hFFFF_FFFF) cnt++;
        end
        default: begin
          q = acc / 60'd3600;
          r.energy = (q > 60'(ENERGY_SAT)) ? ENERGY_SAT : q[47:0];
          r.count = cnt;
          r.first_t = cnt != 0 ? first_t : 0;
          r.last_t = cnt != 0 ? prev_t : 0;
          pending.push_back(r);
          prev_t = 0;
          first_t = 0;
          cnt = 0;
          acc = 0;
        end
      endcase
    endfunction

    function void check_summary(summary_t got);
      summary_t exp_r;
      results++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: energy %0d/%0d count %0d/%0d first %0d/%0d last %0d/%0d",
                   exp_r.energy, got.energy, exp_r.count, got.count,
                   exp_r.first_t, got.first_t, exp_r.last_t, got.last_t);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic [1:0] in_operation = 0;
  logic [3:0] in_slot_index = 0;
  logic [15:0] in_speed = 0;
  logic [19:0] in_curve_power = 0;
  logic signed [15:0] in_status_value = 0;
  logic [31:0] in_sample_time = 0;
  logic [47:0] out_energy;
  logic [31:0] out_sample_count, out_first_time, out_last_time;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  energy_scoreboard sb;
  bit hold_long = 0;
  int n_items = 0;
  logic [31:0] clock_s = 0;

  always #6 clk = ~clk;

  gated_power_curve_energy_integrator_unit uut (.*);

  initial begin
    #30ms;
    $display("gated_power_curve_energy_integrator_unit_tb: done, errors");
    $finish;
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_summary({out_energy, out_sample_count, out_first_time, out_last_time});

  initial begin : receiver
    int w;
    wait (rst_n);
    forever begin
      w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
      if (hold_long) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_long = 0;
      end else if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
    end
  end

  task automatic write_reg(int idx, logic [31:0] v);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= 5'(4 * idx);
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send(logic [1:0] op, logic [3:0] slot, logic [15:0] spd, logic [19:0] pw,
                      logic signed [15:0] st, logic [31:0] t, bit nogap = 0);
    int g;
    g = (nogap || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_slot_index <= slot;
    in_speed <= spd;
    in_curve_power <= pw;
    in_status_value <= st;
    in_sample_time <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transfer(op, slot, spd, pw, st, t);
    n_items++;
  endtask

  task automatic settle();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // sorted random curve at all 16 slots
  task automatic load_curve();
    logic [15:0] s;
    s = $urandom_range(0, 300);
    for (int i = 0; i < gpcei_pkg::CurvePoints; i++) begin
      send(gpcei_pkg::OP_LOAD, 4'(i), s, $urandom_range(0, 3) == 0 ? 20'hFFFFF : 20'($urandom),
           16'($urandom), $urandom);
      s = s + 16'($urandom_range(1, 3000));
      if (s < 16'd200) s = 16'hFFFF;
    end
  endtask

  task automatic random_item();
    int k;
    logic [31:0] t;
    k = $urandom_range(0, 99);
    if (k < 60) begin
      t = clock_s + $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0) t = $urandom;
      clock_s = t;
      send(gpcei_pkg::OP_SAMPLE, 4'($urandom), $urandom_range(0, 3) == 0 ? 16'($urandom) :
           16'($urandom_range(0, 20000)), 20'($urandom), 16'($urandom), t);
    end else if (k < 85) begin
      send(gpcei_pkg::OP_STATUS, 4'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2)),
           16'($urandom), 20'($urandom),
           $urandom_range(0, 1) ? 16'($urandom_range(0, 10)) : 16'($urandom), $urandom);
    end else if (k < 92) begin
      send(gpcei_pkg::OP_LOAD, 4'($urandom), 16'($urandom), 20'($urandom), 16'($urandom),
           $urandom);
    end else begin
      send(gpcei_pkg::OP_FINISH, 4'($urandom), 16'($urandom), 20'($urandom), 16'($urandom),
           $urandom);
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: empty run, curve with zero points, extremes
    send(gpcei_pkg::OP_FINISH, 0, 0, 0, 0, 0);
    send(gpcei_pkg::OP_SAMPLE, 0, 16'hFFFF, 0, 0, 32'hFFFF_FFFF);
    send(gpcei_pkg::OP_FINISH, 15, 0, 0, 0, 0);
    settle();
    write_reg(gpcei_pkg::REG_POINTS, 31);
    write_reg(gpcei_pkg::REG_CHANS, 3);
    write_reg(gpcei_pkg::REG_C0_LO, 16'h8000); write_reg(gpcei_pkg::REG_C0_HI, 16'h7FFF);
    write_reg(gpcei_pkg::REG_C1_LO, 5); write_reg(gpcei_pkg::REG_C1_HI, 2);
    write_reg(gpcei_pkg::REG_C2_LO, 0); write_reg(gpcei_pkg::REG_C2_HI, 0);
    send(gpcei_pkg::OP_LOAD, 0, 100, 0, 0, 0);
    send(gpcei_pkg::OP_LOAD, 1, 100, 1000, 0, 0);
    send(gpcei_pkg::OP_LOAD, 2, 2000, 20'hFFFFF, 0, 0);
    for (int i = 3; i < gpcei_pkg::CurvePoints; i++)
      send(gpcei_pkg::OP_LOAD, 4'(i), 16'(2000 + i * 3000), 20'(100 * i), 0, 0);
    send(gpcei_pkg::OP_STATUS, 3, 0, 0, 16'h7FFF, 32'hFFFF_FFFF);
    send(gpcei_pkg::OP_STATUS, 0, 0, 0, 16'sh8000, 0);
    send(gpcei_pkg::OP_SAMPLE, 0, 0, 0, 0, 10);
    send(gpcei_pkg::OP_SAMPLE, 0, 150, 0, 0, 20);
    send(gpcei_pkg::OP_SAMPLE, 0, 16'hFFFF, 0, 0, 32'hFFFF_FFFF);
    send(gpcei_pkg::OP_SAMPLE, 0, 1000, 0, 0, 5);
    send(gpcei_pkg::OP_FINISH, 0, 0, 0, 0, 0);
    settle();
    // random phases with varied register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(gpcei_pkg::REG_POINTS, ph == 0 ? 0 : (ph == 1 ? 2 : $urandom_range(1, 16)));
      write_reg(gpcei_pkg::REG_CHANS, ph % 4);
      for (int r = gpcei_pkg::REG_C0_LO; r <= gpcei_pkg::REG_C2_HI; r++)
        write_reg(r, (r % 2 == 0) ? $urandom_range(0, 4) : $urandom_range(3, 12));
      if (ph == 5) write_reg(gpcei_pkg::REG_C0_LO, 16'h7FFF);
      if (ph > 0) load_curve();
      if (ph == 3) hold_long = 1;
      for (int j = 0; j < 55; j++) begin
        random_item();
        if (ph == 3 && j < 12) send(gpcei_pkg::OP_FINISH, 0, 0, 0, 0, 0, 1);
      end
      send(gpcei_pkg::OP_FINISH, 0, 0, 0, 0, 0);
      settle();
    end
    $display("covered %0d transfers in, %0d summaries out, over several register settings",
             n_items, sb.results);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("gated_power_curve_energy_integrator_unit_tb: done, clean");
    else
      $display("gated_power_curve_energy_integrator_unit_tb: done, errors");
    $finish;
  end
endmodule
